// ===== sv/lrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_pkg: shared types and constants for the reconnect backoff controller
// Event codes, radio and retry codes, register indexes, reset values and the
// structs passed between the blocks.
// ----------------------------------------------------------------------------
package lrb_pkg;

  localparam int MAX_NETWORKS_DEF = 8;

  // register reset values
  localparam logic [15:0] BASE_BACKOFF_RST   = 16'd1000;
  localparam logic [15:0] PINNED_BACKOFF_RST = 16'd3000;
  localparam logic [15:0] DBL_LIMIT_RST      = 16'd30000;
  localparam logic [15:0] BACKOFF_CAP_RST    = 16'd60000;
  localparam logic [7:0]  ROTATE_FAILS_RST   = 8'd2;
  localparam logic [7:0]  GIVEUP_FAILS_RST   = 8'd5;

  // backoff state value after reset
  localparam logic [15:0] BACKOFF_STATE_RST  = 16'd1000;

  localparam logic [7:0]  FAIL_CNT_MAX       = 8'd255;

  typedef enum logic [2:0] {
    CFG_BASE_BACKOFF   = 3'd0,
    CFG_PINNED_BACKOFF = 3'd1,
    CFG_DBL_LIMIT      = 3'd2,
    CFG_BACKOFF_CAP    = 3'd3,
    CFG_ROTATE_FAILS   = 3'd4,
    CFG_GIVEUP_FAILS   = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_START        = 4'd0,
    OP_STOP         = 4'd1,
    OP_RADIO_UP     = 4'd2,
    OP_DISCONNECTED = 4'd3,
    OP_GOT_ADDR     = 4'd4,
    OP_PROBE        = 4'd5,
    OP_TIMER        = 4'd6,
    OP_RETRY_NOW    = 4'd7,
    OP_JOIN_NEW     = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    LINK_DOWN   = 2'd0,
    LINK_ONLINE = 2'd1,
    LINK_PORTAL = 2'd2
  } link_state_t;

  typedef enum logic [2:0] {
    RADIO_NONE       = 3'd0,
    RADIO_CONNECT    = 3'd1,
    RADIO_DISCONNECT = 3'd2,
    RADIO_STOP       = 3'd3,
    RADIO_START      = 3'd4,
    RADIO_RECONNECT  = 3'd5
  } radio_cmd_t;

  typedef enum logic [1:0] {
    RETRY_NONE   = 2'd0,
    RETRY_ARM    = 2'd1,
    RETRY_CANCEL = 2'd2
  } retry_t;

  typedef struct packed {
    logic [15:0] base_backoff;
    logic [15:0] pinned_backoff;
    logic [15:0] dbl_limit;
    logic [15:0] backoff_cap;
    logic [7:0]  rotate_fails;
    logic [7:0]  giveup_fails;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] network_count;
    logic       probe_online;
  } evt_t;

  typedef struct packed {
    logic [1:0]  link_state;
    logic        state_changed;
    logic [2:0]  net_index;
    logic        apply_network;
    logic [2:0]  radio_cmd;
    logic [1:0]  retry_action;
    logic [15:0] retry_delay_ms;
    logic [2:0]  promote_index;
    logic        probe_kick;
    logic        probe_stop;
    logic        join_failed;
    logic        has_address;
  } res_t;

endpackage

// ===== sv/lrb_evt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_evt_if: link event channel
// Valid/ready channel carrying one link event word.
// ----------------------------------------------------------------------------
interface lrb_evt_if;
  logic       valid;
  logic       ready;
  logic [3:0] op;
  logic [3:0] network_count;
  logic       probe_online;

  modport source (output valid, op, network_count, probe_online, input ready);
  modport sink   (input valid, op, network_count, probe_online, output ready);
endinterface

// ===== sv/lrb_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_res_if: controller result channel
// Valid/ready channel carrying one result word per event.
// ----------------------------------------------------------------------------
interface lrb_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  link_state;
  logic        state_changed;
  logic [2:0]  net_index;
  logic        apply_network;
  logic [2:0]  radio_cmd;
  logic [1:0]  retry_action;
  logic [15:0] retry_delay_ms;
  logic [2:0]  promote_index;
  logic        probe_kick;
  logic        probe_stop;
  logic        join_failed;
  logic        has_address;

  modport source (output valid, link_state, state_changed, net_index, apply_network,
                  radio_cmd, retry_action, retry_delay_ms, promote_index, probe_kick,
                  probe_stop, join_failed, has_address, input ready);
  modport sink   (input valid, link_state, state_changed, net_index, apply_network,
                  radio_cmd, retry_action, retry_delay_ms, promote_index, probe_kick,
                  probe_stop, join_failed, has_address, output ready);
endinterface

// ===== sv/link_reconnect_backoff_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_reconnect_backoff_controller: station link reconnect controller
// Turns link events into radio commands, retry timer requests with
// exponential backoff, network rotation/promotion and link-state reports.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake              word
//  -------   ---   ---------------------  -------------------------------------
//  in_ch     in    valid/ready            op, network_count, probe_online
//  out_ch    out   valid/ready            link_state ... has_address (12 fields)
//  cfg_*     in    cfg_we, no stall       cfg_idx selects, cfg_wdata[15:0]
//
//  Timing: an accepted event is held in the input register, then its result
//  word in the result register; one word per cycle sustained while out_ch
//  takes each result word, as the state update in lrb_event_core is
//  combinational and commits with advance.
//  Reset: synchronous rst_n clears both stages and the link state and loads
//  the register defaults.
//  Stalls: a held result stops the state update; the input register still
//  takes one more word, then in_ch.ready drops until out_ch drains.
//
module link_reconnect_backoff_controller #(
  parameter int MaxNetworks = lrb_pkg::MAX_NETWORKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lrb_evt_if.sink     in_ch,
  lrb_res_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  lrb_pkg::cfg_t cfg;
  lrb_pkg::evt_t evt_r;
  lrb_pkg::res_t res_nxt;
  lrb_pkg::res_t res_r;
  logic          in_v_r;
  logic          out_v_r;
  logic          advance;  // input word moves through the core into the result reg

  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  lrb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lrb_event_core #(
    .MaxNetworks (MaxNetworks)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .evt   (evt_r),
    .cfg   (cfg),
    .res   (res_nxt)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      evt_r.op            <= in_ch.op;
      evt_r.network_count <= in_ch.network_count;
      evt_r.probe_online  <= in_ch.probe_online;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.link_state     = res_r.link_state;
  assign out_ch.state_changed  = res_r.state_changed;
  assign out_ch.net_index      = res_r.net_index;
  assign out_ch.apply_network  = res_r.apply_network;
  assign out_ch.radio_cmd      = res_r.radio_cmd;
  assign out_ch.retry_action   = res_r.retry_action;
  assign out_ch.retry_delay_ms = res_r.retry_delay_ms;
  assign out_ch.promote_index  = res_r.promote_index;
  assign out_ch.probe_kick     = res_r.probe_kick;
  assign out_ch.probe_stop     = res_r.probe_stop;
  assign out_ch.join_failed    = res_r.join_failed;
  assign out_ch.has_address    = res_r.has_address;

  // a word entering the result stage is offered on the next cycle
  a_adv_shows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("result word lost after advance");

  // a delay only travels with an arm request
  a_delay_arm: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.retry_action != lrb_pkg::RETRY_ARM) |-> res_nxt.retry_delay_ms == 16'd0)
    else $error("retry delay without arm");

  // promotion moves the selected network to slot zero
  a_promote_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.promote_index != 3'd0) |-> res_nxt.net_index == 3'd0)
    else $error("promotion left a nonzero index");

  // with the result stage full and stalled, the core must not advance
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |-> !advance)
    else $error("core advanced over a stalled result");

endmodule

// ===== sv/lrb_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_cfg_regs: configuration register file
// Six write-only timing and threshold registers with reset defaults.
// ----------------------------------------------------------------------------
module lrb_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_idx,
  input  logic [15:0]   cfg_wdata,
  output lrb_pkg::cfg_t cfg
);

  lrb_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (lrb_pkg::cfg_idx_t'(cfg_idx))
        lrb_pkg::CFG_BASE_BACKOFF:   cfg_nxt.base_backoff   = cfg_wdata;
        lrb_pkg::CFG_PINNED_BACKOFF: cfg_nxt.pinned_backoff = cfg_wdata;
        lrb_pkg::CFG_DBL_LIMIT:      cfg_nxt.dbl_limit      = cfg_wdata;
        lrb_pkg::CFG_BACKOFF_CAP:    cfg_nxt.backoff_cap    = cfg_wdata;
        lrb_pkg::CFG_ROTATE_FAILS:   cfg_nxt.rotate_fails   = cfg_wdata[7:0];
        lrb_pkg::CFG_GIVEUP_FAILS:   cfg_nxt.giveup_fails   = cfg_wdata[7:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_backoff   <= lrb_pkg::BASE_BACKOFF_RST;
      cfg_r.pinned_backoff <= lrb_pkg::PINNED_BACKOFF_RST;
      cfg_r.dbl_limit      <= lrb_pkg::DBL_LIMIT_RST;
      cfg_r.backoff_cap    <= lrb_pkg::BACKOFF_CAP_RST;
      cfg_r.rotate_fails   <= lrb_pkg::ROTATE_FAILS_RST;
      cfg_r.giveup_fails   <= lrb_pkg::GIVEUP_FAILS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/lrb_event_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_event_core: link state registers and per-event update
// Holds the controller state and computes the result word and next state
// for one event; state commits when fire is high.
// ----------------------------------------------------------------------------
module lrb_event_core #(
  parameter int MaxNetworks = lrb_pkg::MAX_NETWORKS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  lrb_pkg::evt_t evt,
  input  lrb_pkg::cfg_t cfg,
  output lrb_pkg::res_t res
);

  localparam logic [4:0] MAX_W   = 5'(MaxNetworks);
  localparam logic [3:0] MAX_CNT = 4'(MaxNetworks);

  lrb_pkg::link_state_t last_state_r, last_state_nxt;
  logic        enabled_r, enabled_nxt;
  logic        has_ip_r, has_ip_nxt;
  logic [15:0] backoff_r, backoff_nxt;
  logic [3:0]  known_cnt_r, known_cnt_nxt;
  logic [2:0]  cur_idx_r, cur_idx_nxt;
  logic [7:0]  fail_cnt_r, fail_cnt_nxt;
  logic        pinned_r, pinned_nxt;
  logic        pin_failed_r, pin_failed_nxt;

  logic [3:0]  cnt_clamped;
  logic [7:0]  fail_inc;
  logic [3:0]  idx_plus;
  logic [3:0]  idx_wrap;
  logic [15:0] backoff_dbl;

  assign cnt_clamped = ({1'b0, evt.network_count} > MAX_W) ? MAX_CNT : evt.network_count;
  assign fail_inc    = (fail_cnt_r < lrb_pkg::FAIL_CNT_MAX) ? fail_cnt_r + 8'd1 : fail_cnt_r;
  assign idx_plus    = {1'b0, cur_idx_r} + 4'd1;
  // index stays below the known count, so one subtract wraps it
  assign idx_wrap    = (idx_plus >= known_cnt_r) ? idx_plus - known_cnt_r : idx_plus;
  assign backoff_dbl = backoff_r[15] ? 16'hFFFF : {backoff_r[14:0], 1'b0};

  always_comb begin
    lrb_pkg::link_state_t st;
    last_state_nxt = last_state_r;
    enabled_nxt    = enabled_r;
    has_ip_nxt     = has_ip_r;
    backoff_nxt    = backoff_r;
    known_cnt_nxt  = known_cnt_r;
    cur_idx_nxt    = cur_idx_r;
    fail_cnt_nxt   = fail_cnt_r;
    pinned_nxt     = pinned_r;
    pin_failed_nxt = pin_failed_r;
    st             = last_state_r;

    res                = '0;
    res.radio_cmd      = lrb_pkg::RADIO_NONE;
    res.retry_action   = lrb_pkg::RETRY_NONE;

    case (lrb_pkg::op_t'(evt.op))
      lrb_pkg::OP_START: begin
        known_cnt_nxt = cnt_clamped;
        if (cnt_clamped != 4'd0) begin
          cur_idx_nxt       = 3'd0;
          fail_cnt_nxt      = 8'd0;
          pinned_nxt        = 1'b0;
          pin_failed_nxt    = 1'b0;
          enabled_nxt       = 1'b1;
          res.apply_network = 1'b1;
          res.radio_cmd     = lrb_pkg::RADIO_START;
        end
      end
      lrb_pkg::OP_STOP: begin
        enabled_nxt      = 1'b0;
        res.retry_action = lrb_pkg::RETRY_CANCEL;
        res.probe_stop   = 1'b1;
        res.radio_cmd    = lrb_pkg::RADIO_STOP;
        has_ip_nxt       = 1'b0;
        pinned_nxt       = 1'b0;
        pin_failed_nxt   = 1'b0;
        st               = lrb_pkg::LINK_DOWN;
      end
      lrb_pkg::OP_RADIO_UP: begin
        res.radio_cmd = lrb_pkg::RADIO_CONNECT;
      end
      lrb_pkg::OP_DISCONNECTED: begin
        has_ip_nxt     = 1'b0;
        res.probe_stop = 1'b1;
        st             = lrb_pkg::LINK_DOWN;
        if (enabled_r) begin
          fail_cnt_nxt = fail_inc;
          if (pinned_r) begin
            if (fail_inc >= cfg.giveup_fails) pin_failed_nxt = 1'b1;
          end else if (fail_inc >= cfg.rotate_fails && known_cnt_r > 4'd1) begin
            fail_cnt_nxt      = 8'd0;
            cur_idx_nxt       = idx_wrap[2:0];
            res.apply_network = 1'b1;
          end
          res.retry_action   = lrb_pkg::RETRY_ARM;
          res.retry_delay_ms = backoff_r;
          if (pinned_r)                       backoff_nxt = cfg.pinned_backoff;
          else if (backoff_r >= cfg.dbl_limit) backoff_nxt = cfg.backoff_cap;
          else                                backoff_nxt = backoff_dbl;
        end
      end
      lrb_pkg::OP_GOT_ADDR: begin
        has_ip_nxt     = 1'b1;
        backoff_nxt    = cfg.base_backoff;
        fail_cnt_nxt   = 8'd0;
        pinned_nxt     = 1'b0;
        pin_failed_nxt = 1'b0;
        if (cur_idx_r != 3'd0 && {1'b0, cur_idx_r} < known_cnt_r) begin
          res.promote_index = cur_idx_r;
          cur_idx_nxt       = 3'd0;
        end
        res.probe_kick = 1'b1;
      end
      lrb_pkg::OP_PROBE: begin
        if (enabled_r && has_ip_r) begin
          st = evt.probe_online ? lrb_pkg::LINK_ONLINE : lrb_pkg::LINK_PORTAL;
        end
      end
      lrb_pkg::OP_TIMER: begin
        if (enabled_r) res.radio_cmd = lrb_pkg::RADIO_CONNECT;
      end
      lrb_pkg::OP_RETRY_NOW: begin
        if (enabled_r && !has_ip_r) begin
          backoff_nxt      = cfg.base_backoff;
          res.retry_action = lrb_pkg::RETRY_ARM;
        end
      end
      lrb_pkg::OP_JOIN_NEW: begin
        known_cnt_nxt     = cnt_clamped;
        cur_idx_nxt       = 3'd0;
        fail_cnt_nxt      = 8'd0;
        pinned_nxt        = 1'b1;
        pin_failed_nxt    = 1'b0;
        backoff_nxt       = cfg.base_backoff;
        enabled_nxt       = 1'b1;
        res.radio_cmd     = has_ip_r ? lrb_pkg::RADIO_RECONNECT : lrb_pkg::RADIO_CONNECT;
        res.apply_network = 1'b1;
      end
      default: ;  // unused code: state untouched
    endcase

    last_state_nxt    = st;
    res.state_changed = (st != last_state_r);
    res.link_state    = last_state_nxt;
    res.net_index     = cur_idx_nxt;
    res.join_failed   = pin_failed_nxt;
    res.has_address   = has_ip_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_state_r <= lrb_pkg::LINK_DOWN;
      enabled_r    <= 1'b0;
      has_ip_r     <= 1'b0;
      backoff_r    <= lrb_pkg::BACKOFF_STATE_RST;
      known_cnt_r  <= 4'd0;
      cur_idx_r    <= 3'd0;
      fail_cnt_r   <= 8'd0;
      pinned_r     <= 1'b0;
      pin_failed_r <= 1'b0;
    end else if (fire) begin
      last_state_r <= last_state_nxt;
      enabled_r    <= enabled_nxt;
      has_ip_r     <= has_ip_nxt;
      backoff_r    <= backoff_nxt;
      known_cnt_r  <= known_cnt_nxt;
      cur_idx_r    <= cur_idx_nxt;
      fail_cnt_r   <= fail_cnt_nxt;
      pinned_r     <= pinned_nxt;
      pin_failed_r <= pin_failed_nxt;
    end
  end

endmodule
